/* hdl/ubt_pkg.sv */
// Shared types and command codes for the unordered bag table.
`timescale 1ns / 1ps
`default_nettype none

package ubt_pkg;

  // Command codes carried in the low bits of a request.
  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_GET    = 3'd3,
    CMD_CLEAR  = 3'd4
  } ubt_cmd_t;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_op;
    logic set_refused;
    logic add_write;
    logic clear;
    logic get_read;
    logic get_capture;
    logic scan_start;
    logic scan_step;
    logic move_read;
    logic move_write;
    logic out_load;
  } ubt_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             room;
    logic             pos_ok;
    logic             scan_done;
    logic             hit;
  } ubt_sts_t;

endpackage

`default_nettype wire

/* hdl/ubt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ubt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/ubt_datapath.sv */
// Datapath of the bag table: entry store, count, scan logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module ubt_datapath #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ubt_pkg::ubt_ctl_t                   ctl,
  output      ubt_pkg::ubt_sts_t                   sts,
  input  wire logic [ubt_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic [ubt_pkg::VALUE_W-1:0]         in_item_value,
  input  wire logic [ubt_pkg::POS_W-1:0]           in_position,
  output      logic [ubt_pkg::OUT_TDATA_W-1:0]     out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > ubt_pkg::POS_W) ? CW : ubt_pkg::POS_W;

  logic [ubt_pkg::CMD_W-1:0] op_cmd_r, op_cmd_nxt;
  logic [ITEM_WIDTH-1:0]     op_val_r, op_val_nxt;
  logic [ubt_pkg::POS_W-1:0] op_pos_r, op_pos_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             scan_idx_r, scan_idx_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                      hit_r, hit_nxt;
  logic [AW-1:0]             hit_at_r, hit_at_nxt;
  logic [CW-1:0]             mcount_r, mcount_nxt;
  logic                      refused_r, refused_nxt;
  logic [ITEM_WIDTH-1:0]     rdval_r, rdval_nxt;
  logic [ubt_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [ITEM_WIDTH+ubt_pkg::VALUE_W-1:0] val_wide;
  logic [PW-1:0]             pos_ext;
  logic [PW-1:0]             count_ext;
  logic [CW-1:0]             count_m1;
  logic                      scan_more;
  logic                      is_query;
  logic [CW+ubt_pkg::COUNT_W-1:0]  mcount_wide;
  logic [CW+ubt_pkg::COUNT_W-1:0]  size_wide;
  logic [AW+ubt_pkg::INDEX_W-1:0]  first_wide;
  logic [ITEM_WIDTH+ubt_pkg::VALUE_W-1:0] rdval_wide;
  logic [ubt_pkg::COUNT_W-1:0] res_mcount;
  logic [ubt_pkg::INDEX_W-1:0] res_first;
  logic                      res_found;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ITEM_WIDTH-1:0]     ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [ITEM_WIDTH-1:0]     ram_rdata;

  // Entry store.
  ubt_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Width adjustments and comparisons used by the controller.
  assign val_wide  = {{ubt_pkg::VALUE_W{1'b0}}, ITEM_WIDTH'(0)} | 
                     {{ITEM_WIDTH{1'b0}}, in_item_value};
  assign pos_ext   = PW'(op_pos_r);
  assign count_ext = PW'(count_r);
  assign count_m1  = count_r - 1'b1;
  assign scan_more = (scan_idx_r < count_r);

  assign sts.op        = op_cmd_r;
  assign sts.room      = (count_r < CW'(CAPACITY));
  assign sts.pos_ok    = (pos_ext < count_ext);
  assign sts.scan_done = !scan_more && !cmp_vld_r;
  assign sts.hit       = hit_r;

  // Result fields, reduced to the widths of the result item.
  assign is_query    = (op_cmd_r == ubt_pkg::CMD_QUERY);
  assign mcount_wide = {{ubt_pkg::COUNT_W{1'b0}}, mcount_r};
  assign size_wide   = {{ubt_pkg::COUNT_W{1'b0}}, count_r};
  assign first_wide  = {{ubt_pkg::INDEX_W{1'b0}}, hit_at_r};
  assign rdval_wide  = {{ubt_pkg::VALUE_W{1'b0}}, rdval_r};
  assign res_mcount  = is_query ? mcount_wide[ubt_pkg::COUNT_W-1:0] : '0;
  assign res_found   = is_query && hit_r;
  assign res_first   = res_found ? first_wide[ubt_pkg::INDEX_W-1:0] : '0;

  // Next-state logic driven by the controller's commands.
  always_comb begin
    op_cmd_nxt   = op_cmd_r;
    op_val_nxt   = op_val_r;
    op_pos_nxt   = op_pos_r;
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    hit_nxt      = hit_r;
    hit_at_nxt   = hit_at_r;
    mcount_nxt   = mcount_r;
    refused_nxt  = refused_r;
    rdval_nxt    = rdval_r;
    out_data_nxt = out_data_r;
    ram_we       = 1'b0;
    ram_waddr    = count_r[AW-1:0];
    ram_wdata    = op_val_r;
    ram_raddr    = scan_idx_r[AW-1:0];

    if (ctl.load_op) begin
      op_cmd_nxt  = in_cmd;
      op_val_nxt  = val_wide[ITEM_WIDTH-1:0];
      op_pos_nxt  = in_position;
      refused_nxt = 1'b0;
      rdval_nxt   = '0;
    end
    if (ctl.set_refused) begin
      refused_nxt = 1'b1;
    end
    // Append at the end of the table.
    if (ctl.add_write) begin
      ram_we    = 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (ctl.clear) begin
      count_nxt = '0;
    end
    // Read by position, data captured in the following cycle.
    if (ctl.get_read) begin
      ram_raddr = pos_ext[AW-1:0];
    end
    if (ctl.get_capture) begin
      rdval_nxt = ram_rdata;
    end
    // Linear scan: one read issued and one compare done per cycle.
    if (ctl.scan_start) begin
      scan_idx_nxt = '0;
      hit_nxt      = 1'b0;
      hit_at_nxt   = '0;
      mcount_nxt   = '0;
    end
    if (ctl.scan_step && scan_more) begin
      cmp_vld_nxt  = 1'b1;
      cmp_idx_nxt  = scan_idx_r[AW-1:0];
      scan_idx_nxt = scan_idx_r + 1'b1;
    end
    if (cmp_vld_r && (ram_rdata == op_val_r)) begin
      mcount_nxt = mcount_r + 1'b1;
      if (!hit_r) begin
        hit_nxt    = 1'b1;
        hit_at_nxt = cmp_idx_r;
      end
    end
    // Remove: fetch the last entry, then move it into the hole.
    if (ctl.move_read) begin
      count_nxt = count_m1;
      ram_raddr = count_m1[AW-1:0];
    end
    if (ctl.move_write) begin
      ram_we    = 1'b1;
      ram_waddr = hit_at_r;
      ram_wdata = ram_rdata;
    end
    // Result register.
    if (ctl.out_load) begin
      out_data_nxt = {6'd0,
                      (count_r == CW'(CAPACITY)),
                      (count_r == '0),
                      size_wide[ubt_pkg::COUNT_W-1:0],
                      rdval_wide[ubt_pkg::VALUE_W-1:0],
                      res_first,
                      res_found,
                      res_mcount,
                      refused_r};
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_cmd_r   <= op_cmd_nxt;
    op_val_r   <= op_val_nxt;
    op_pos_r   <= op_pos_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_r      <= hit_nxt;
    hit_at_r   <= hit_at_nxt;
    mcount_r   <= mcount_nxt;
    refused_r  <= refused_nxt;
    rdval_r    <= rdval_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

/* hdl/ubt_ctrl.sv */
// Controller state machine of the bag table.
`timescale 1ns / 1ps
`default_nettype none

module ubt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      ubt_pkg::ubt_ctl_t ctl,
  input  wire ubt_pkg::ubt_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_GET_WAIT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl.load_op = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FINISH;
        unique case (sts.op)
          ubt_pkg::CMD_ADD: begin
            if (sts.room) begin
              ctl.add_write = 1'b1;
            end else begin
              ctl.set_refused = 1'b1;
            end
          end
          ubt_pkg::CMD_REMOVE, ubt_pkg::CMD_QUERY: begin
            ctl.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
          ubt_pkg::CMD_GET: begin
            if (sts.pos_ok) begin
              ctl.get_read = 1'b1;
              state_nxt    = ST_GET_WAIT;
            end else begin
              ctl.set_refused = 1'b1;
            end
          end
          ubt_pkg::CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
          if (sts.op == ubt_pkg::CMD_REMOVE) begin
            if (sts.hit) begin
              state_nxt = ST_MOVE_RD;
            end else begin
              ctl.set_refused = 1'b1;
            end
          end
        end
      end
      ST_MOVE_RD: begin
        ctl.move_read = 1'b1;
        state_nxt     = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        ctl.move_write = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_GET_WAIT: begin
        ctl.get_capture = 1'b1;
        state_nxt       = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until taken; a new one is loaded only into a free slot.
  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/unordered_bag_table.sv */
// Top level of the unordered bag table: controller, datapath and stream ports.
//
// Usage:
// Requests enter on the in_ stream, one command each (add, remove, query,
// get, clear); every request yields exactly one result on the out_ stream,
// in order. Each result carries a refusal flag, query fields, the value
// read by get, and the table size with empty and full flags after the
// command.
// After acceptance each request is decoded; add, clear, unused codes and a
// refused get then load their result, a successful get first captures the
// read entry, and query and remove first scan every entry below the count,
// a matching remove then fetching the last entry and moving it into the hole.
// The linear scan over the single-read entry RAM compares one entry per cycle,
// so scan time grows with the table size. The next request is accepted the
// cycle after the result is loaded, even while the last result is still
// waiting to be taken.
// Reset empties the table at once, as entries beyond the count are never
// read. When the receiver stalls, the result register holds its contents and
// the controller waits with the next result until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module unordered_bag_table #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [2:0] cmd, [34:3] item_value, [38:35] position, [39] zero
  input  wire logic [39:0] in_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [0] status, [5:1] match_count, [6] match_found, [10:7] first_index,
  // [42:11] read_value, [47:43] size_now, [48] is_empty, [49] is_full,
  // [55:50] zero
  output      logic [55:0] out_tdata
);

  ubt_pkg::ubt_ctl_t ctl;
  ubt_pkg::ubt_sts_t sts;

  // Sequencer.
  ubt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .sts        (sts)
  );

  // Storage and compare logic.
  ubt_datapath #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (in_tdata[2:0]),
    .in_item_value (in_tdata[34:3]),
    .in_position   (in_tdata[38:35]),
    .out_data      (out_tdata)
  );

endmodule

`default_nettype wire

/* hdl/ubt_checker.sv */
// Port-level checks for the bag table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ubt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The empty flag agrees with the reported size.
  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[48] == (out_tdata[47:43] == 5'd0)))
    else $error("empty flag disagrees with size");

  // A full table is never empty.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[49] |-> !out_tdata[48])
    else $error("full and empty at once");

  // Without a match, the count and the first index are zero.
  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[6] |-> (out_tdata[5:1] == 5'd0) && (out_tdata[10:7] == 4'd0))
    else $error("match fields set without a match");

  // A query with a match is never refused.
  a_match_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> !out_tdata[0])
    else $error("refused result reports a match");

endmodule

bind unordered_bag_table ubt_checker u_ubt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* sim/ubt_checker.sv */
// Checker for the unordered bag table: predicts every result and compares it.
`timescale 1ns / 1ps

module ubt_scoreboard #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // [2:0] cmd, [34:3] item_value, [38:35] position, [39] zero
  input  wire logic [ubt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // [0] status, [5:1] match_count, [6] match_found, [10:7] first_index,
  // [42:11] read_value, [47:43] size_now, [48] is_empty, [49] is_full
  input  wire logic [ubt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      int                              fail_total,
  output      int                              replies_owed,
  output      int                              replies_checked,
  output      int                              refusals_seen
);

  // One result, laid out so that the low 50 bits of out_tdata map onto it.
  typedef struct packed {
    logic                        is_full;
    logic                        is_empty;
    logic [ubt_pkg::COUNT_W-1:0] size_now;
    logic [ubt_pkg::VALUE_W-1:0] read_value;
    logic [ubt_pkg::INDEX_W-1:0] first_index;
    logic                        match_found;
    logic [ubt_pkg::COUNT_W-1:0] match_count;
    logic                        status;
  } bag_reply_t;

  // Our own copy of the table.
  logic [ubt_pkg::VALUE_W-1:0] bag_entries [CAPACITY];
  int unsigned                 bag_size = 0;

  bag_reply_t replies_due [$];
  bag_reply_t want_reply;
  bag_reply_t got_reply;
  bag_reply_t next_reply;
  int         mismatch_count = 0;
  int         checked_count  = 0;
  int         refused_count  = 0;

  assign fail_total      = mismatch_count;
  assign replies_owed    = replies_due.size();
  assign replies_checked = checked_count;
  assign refusals_seen   = refused_count;

  // Applies one request to the table copy and returns the result it causes.
  function automatic bag_reply_t bag_apply(input logic [ubt_pkg::CMD_W-1:0]   op,
                                           input logic [ubt_pkg::VALUE_W-1:0] val,
                                           input logic [ubt_pkg::POS_W-1:0]   pos);
    bag_reply_t  r;
    int unsigned hits;
    int unsigned first_hit;
    bit          seen;
    r         = '0;
    hits      = 0;
    first_hit = 0;
    seen      = 1'b0;
    // Remove and query both scan the valid entries for the first match.
    if (op == ubt_pkg::CMD_REMOVE || op == ubt_pkg::CMD_QUERY) begin
      for (int unsigned i = 0; i < bag_size; i++) begin
        if (bag_entries[i] == val) begin
          if (!seen) begin
            seen      = 1'b1;
            first_hit = i;
          end
          hits++;
        end
      end
    end
    case (op)
      ubt_pkg::CMD_ADD: begin
        if (bag_size < CAPACITY) begin
          bag_entries[bag_size] = val;
          bag_size++;
        end else begin
          r.status = 1'b1;
        end
      end
      ubt_pkg::CMD_REMOVE: begin
        // The last entry fills the hole left by the removed one.
        if (seen) begin
          bag_size--;
          bag_entries[first_hit] = bag_entries[bag_size];
        end else begin
          r.status = 1'b1;
        end
      end
      ubt_pkg::CMD_QUERY: begin
        r.match_count = ubt_pkg::COUNT_W'(hits);
        r.match_found = seen;
        r.first_index = ubt_pkg::INDEX_W'(first_hit);
      end
      ubt_pkg::CMD_GET: begin
        if (pos < bag_size) begin
          r.read_value = bag_entries[pos];
        end else begin
          r.status = 1'b1;
        end
      end
      ubt_pkg::CMD_CLEAR: begin
        bag_size = 0;
      end
      default: begin
      end
    endcase
    r.size_now = ubt_pkg::COUNT_W'(bag_size);
    r.is_empty = (bag_size == 0);
    r.is_full  = (bag_size == CAPACITY);
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(input string name, input logic [ubt_pkg::VALUE_W-1:0] want,
                               input logic [ubt_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Results are matched first, then the request taken at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      bag_size = 0;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_reply = bag_reply_t'(out_tdata[$bits(bag_reply_t)-1:0]);
        if (replies_due.size() == 0) begin
          $error("result 0x%0h arrived with no request outstanding", out_tdata);
          mismatch_count++;
        end else begin
          want_reply = replies_due.pop_front();
          compare_field("status",      want_reply.status,      got_reply.status);
          compare_field("match_count", want_reply.match_count, got_reply.match_count);
          compare_field("match_found", want_reply.match_found, got_reply.match_found);
          compare_field("first_index", want_reply.first_index, got_reply.first_index);
          compare_field("read_value",  want_reply.read_value,  got_reply.read_value);
          compare_field("size_now",    want_reply.size_now,    got_reply.size_now);
          compare_field("is_empty",    want_reply.is_empty,    got_reply.is_empty);
          compare_field("is_full",     want_reply.is_full,     got_reply.is_full);
          checked_count++;
          if (want_reply.status) begin
            refused_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        next_reply = bag_apply(
          in_tdata[ubt_pkg::CMD_W-1:0],
          in_tdata[ubt_pkg::CMD_W+ubt_pkg::VALUE_W-1:ubt_pkg::CMD_W],
          in_tdata[ubt_pkg::CMD_W+ubt_pkg::VALUE_W+ubt_pkg::POS_W-1:
                   ubt_pkg::CMD_W+ubt_pkg::VALUE_W]);
        replies_due = {replies_due, next_reply};
      end
    end
  end

endmodule

/* sim/unordered_bag_table_tb.sv */
// Testbench top for the unordered bag table: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module unordered_bag_table_tb;

  localparam int          RANDOM_ITEMS  = 950;
  localparam int          CALM_TAIL     = 120;
  localparam int          SQUEEZE_AT    = 300;
  localparam int          SQUEEZE_LEN   = 400;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 30;
  localparam logic [31:0] DUP_VALUE     = 32'hA5A5_A5A5;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // [2:0] cmd, [34:3] item_value, [38:35] position, [39] zero
  logic [ubt_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [0] status, [5:1] match_count, [6] match_found, [10:7] first_index,
  // [42:11] read_value, [47:43] size_now, [48] is_empty, [49] is_full
  logic [ubt_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_total;
  int replies_owed;
  int replies_checked;
  int refusals_seen;

  bit          calm        = 1'b0;
  bit          squeeze_now = 1'b0;
  int          sent_by_op [8];
  int          quiet_cycles = 0;
  logic [31:0] value_pool [8];

  unordered_bag_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ubt_scoreboard u_scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_total      (fail_total),
    .replies_owed    (replies_owed),
    .replies_checked (replies_checked),
    .refusals_seen   (refusals_seen)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("unordered_bag_table_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random ready bursts, one long hold-off, and no stalls in the tail.
  initial begin : result_sink
    bit squeezed;
    squeezed = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_now && !squeezed) begin
        squeezed = 1'b1;
        out_tready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Offers one request and holds it until the block takes it.
  task automatic send_request(input logic [ubt_pkg::CMD_W-1:0]   op,
                              input logic [ubt_pkg::VALUE_W-1:0] val,
                              input logic [ubt_pkg::POS_W-1:0]   pos);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, val, op};
    do @(posedge clk); while (!in_tready);
    sent_by_op[op]++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Request side and verdict.
  initial begin
    logic [ubt_pkg::CMD_W-1:0]   op;
    logic [ubt_pkg::VALUE_W-1:0] val;
    logic [ubt_pkg::POS_W-1:0]   pos;
    bit                          filling;
    int                          mode_left;
    int                          w;
    int                          add_cut;
    int                          rem_cut;
    int                          qry_cut;

    foreach (sent_by_op[k]) sent_by_op[k] = 0;
    // A small pool of values makes duplicates and successful searches common.
    for (int k = 0; k < 6; k++) value_pool[k] = $urandom;
    value_pool[6] = 32'h0000_0000;
    value_pool[7] = 32'hFFFF_FFFF;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the empty table, unused codes, filling up and refusal when full.
    send_request(ubt_pkg::CMD_QUERY,  DUP_VALUE, 4'd0);
    send_request(ubt_pkg::CMD_REMOVE, DUP_VALUE, 4'd0);
    send_request(CMD_UNUSED_LO, 32'hFFFF_FFFF, 4'd15);
    send_request(ubt_pkg::CMD_ADD, 32'h0000_0000, 4'd0);
    send_request(ubt_pkg::CMD_ADD, 32'hFFFF_FFFF, 4'd15);
    for (int k = 0; k < 14; k++) begin
      send_request(ubt_pkg::CMD_ADD, (k % 3 == 0) ? DUP_VALUE : $urandom,
                   4'($urandom_range(0, 15)));
    end
    send_request(ubt_pkg::CMD_ADD, DUP_VALUE, 4'd0);
    // Several copies of one value: count, first position, then removal that moves the last.
    send_request(ubt_pkg::CMD_QUERY,  DUP_VALUE, 4'd0);
    send_request(ubt_pkg::CMD_GET,    32'h0,     4'd15);
    send_request(ubt_pkg::CMD_REMOVE, DUP_VALUE, 4'd0);
    send_request(CMD_UNUSED_HI, 32'h0, 4'd0);
    // Clear keeps the old values but a get afterwards must be refused.
    send_request(ubt_pkg::CMD_CLEAR, 32'h0, 4'd0);
    send_request(ubt_pkg::CMD_GET,   32'h0, 4'd0);

    // Random part: alternating stretches that fill the table and drain it.
    filling   = 1'b1;
    mode_left = $urandom_range(20, 60);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        filling   = !filling;
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      if (n == SQUEEZE_AT) squeeze_now = 1'b1;
      if (n == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;

      add_cut = filling ? 55 : 20;
      rem_cut = filling ? 67 : 55;
      qry_cut = filling ? 80 : 72;
      w = $urandom_range(0, 99);
      if (w < add_cut) op = ubt_pkg::CMD_ADD;
      else if (w < rem_cut) op = ubt_pkg::CMD_REMOVE;
      else if (w < qry_cut) op = ubt_pkg::CMD_QUERY;
      else if (w < 94) op = ubt_pkg::CMD_GET;
      else if (w < 96) op = ubt_pkg::CMD_CLEAR;
      else op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));

      if ($urandom_range(0, 9) < 7) begin
        val = value_pool[$urandom_range(0, ($urandom_range(0, 1) != 0) ? 2 : 7)];
      end else begin
        val = $urandom;
      end
      pos = 4'($urandom_range(0, 15));
      send_request(op, val, pos);
    end
    in_tvalid <= 1'b0;

    // Wait for every outstanding result, then a little longer for stray output.
    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d add, %0d remove, %0d query, %0d get, %0d clear, %0d unused requests.",
             sent_by_op[ubt_pkg::CMD_ADD], sent_by_op[ubt_pkg::CMD_REMOVE],
             sent_by_op[ubt_pkg::CMD_QUERY], sent_by_op[ubt_pkg::CMD_GET],
             sent_by_op[ubt_pkg::CMD_CLEAR],
             sent_by_op[CMD_UNUSED_LO] + sent_by_op[CMD_UNUSED_LO + 3'd1] +
             sent_by_op[CMD_UNUSED_HI]);
    $display("Compared %0d results, %0d refused, with a long result stall mid-run.",
             replies_checked, refusals_seen);
    if (fail_total == 0 && replies_owed == 0) begin
      $display("unordered_bag_table_tb: PASS");
    end else begin
      $display("unordered_bag_table_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ubt_pkg.sv
hdl/ubt_ram.sv
hdl/ubt_datapath.sv
hdl/ubt_ctrl.sv
hdl/unordered_bag_table.sv
hdl/ubt_checker.sv
sim/ubt_checker.sv
sim/unordered_bag_table_tb.sv
